FILE: rtl/grid_diffusion_euler_solver_macros.svh
// Assertion macros shared by the solver's RTL.
`ifndef GRID_DIFFUSION_EULER_SOLVER_MACROS_SVH
`define GRID_DIFFUSION_EULER_SOLVER_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define GDES_ASSERT_IMPL(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: property failed");

// The expression must never be true at a clock edge outside reset.
`define GDES_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("%m: forbidden condition seen");

`else

`define GDES_ASSERT_IMPL(lbl, clk, rst_n, prop)
`define GDES_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

FILE: rtl/gdes_pkg.sv
package gdes_pkg;

  // Command codes carried in the func field.
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_RUN   = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_COEF_X    = 3'd0;
  localparam logic [2:0] CFG_COEF_Y    = 3'd1;
  localparam logic [2:0] CFG_TIME_STEP = 3'd2;
  localparam logic [2:0] CFG_THRESHOLD = 3'd3;
  localparam logic [2:0] CFG_OFFSET    = 3'd4;
  localparam logic [2:0] CFG_MAX_ITER  = 3'd5;

  // Cycles spent after the last grid read of a sweep until every write
  // and the convergence flag have settled; the controller counts to this.
  localparam logic [2:0] DRAIN_LAST = 3'd6;

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_READ  = 7'b0000100,
    ST_SWEEP = 7'b0001000,
    ST_DRAIN = 7'b0010000,
    ST_CLAMP = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_e;

  // Tag that travels with the cell at the centre of the stencil.
  typedef struct packed {
    logic valid;
    logic c_first;
    logic c_last;
    logic r_first;
    logic r_last;
  } sweep_tag_t;

  typedef struct packed {
    logic       clear;
    logic       host_wr;
    logic       host_rd;
    logic       sweep_init;
    logic       clamp_rd;
    sweep_tag_t tag;
  } cmd_t;

  typedef struct packed {
    logic       load;
    logic       is_read;
    logic       is_run;
    logic [9:0] sweep_count;
    logic       converged;
  } res_t;

endpackage

FILE: rtl/grid_diffusion_euler_solver.sv
// Explicit Euler diffusion solver over a grid of GRID_ROWS x GRID_COLS cells.
// Commands arrive on the input channel (valid/stall); each command gives
// exactly one result on the output channel (valid/stall). A transfer happens
// on a rising edge with valid high and stall low. Registers are written over
// a separate valid/ready port that is always ready.
// A run command walks the grid once per sweep through a single-read-port
// memory, followed by one pass that clamps values that are not positive to
// zero. After reset the block clears both grid memories, with the input
// stalled; configuration writes are taken throughout.
// A new command is taken only when the controller is idle and the result
// register is empty or being emptied in the same cycle; while the receiver
// stalls, the result is held and further commands wait.
`include "grid_diffusion_euler_solver_macros.svh"

module grid_diffusion_euler_solver #(
  parameter int GRID_COLS  = 64,
  parameter int GRID_ROWS  = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         func_i,
  input  logic [5:0]         col_index_i,
  input  logic [5:0]         row_index_i,
  input  logic signed [31:0] cell_value_in_i,
  input  logic signed [31:0] production_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] cell_value_out_o,
  output logic [9:0]         iterations_done_o,
  output logic               converged_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam int AW = $clog2(GRID_COLS * GRID_ROWS);

  // Configuration registers, loaded with their documented reset values.
  logic [15:0] coef_x_q, coef_y_q, time_step_q, threshold_q, offset_q;
  logic [9:0]  max_iter_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_x_q    <= 16'd16384;
      coef_y_q    <= 16'd16384;
      time_step_q <= 16'd655;
      threshold_q <= 16'd1;
      offset_q    <= 16'd7;
      max_iter_q  <= 10'd100;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        gdes_pkg::CFG_COEF_X:    coef_x_q    <= cfg_data_i;
        gdes_pkg::CFG_COEF_Y:    coef_y_q    <= cfg_data_i;
        gdes_pkg::CFG_TIME_STEP: time_step_q <= cfg_data_i;
        gdes_pkg::CFG_THRESHOLD: threshold_q <= cfg_data_i;
        gdes_pkg::CFG_OFFSET:    offset_q    <= cfg_data_i;
        gdes_pkg::CFG_MAX_ITER:  max_iter_q  <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Input acceptance: the controller must be idle and the result register
  // must have room by the end of this cycle.
  logic ctl_idle;
  logic out_valid_q;
  logic in_accept;

  assign in_stall_o = !ctl_idle || (out_valid_q && out_stall_i);
  assign in_accept  = in_valid_i && !in_stall_o;

  gdes_pkg::cmd_t cmd;
  gdes_pkg::res_t res;
  logic [AW-1:0]  ctl_addr, center_addr;
  logic           sweep_ok;
  logic signed [31:0] rd_value;

  gdes_ctrl #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .func_i        (func_i),
    .max_iter_i    (max_iter_q),
    .ok_i          (sweep_ok),
    .cmd_o         (cmd),
    .res_o         (res),
    .ctl_addr_o    (ctl_addr),
    .center_addr_o (center_addr),
    .idle_o        (ctl_idle)
  );

  gdes_datapath #(
    .GRID_COLS  (GRID_COLS),
    .GRID_ROWS  (GRID_ROWS),
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .ctl_addr_i      (ctl_addr),
    .center_addr_i   (center_addr),
    .col_index_i     (col_index_i),
    .row_index_i     (row_index_i),
    .cell_value_in_i (cell_value_in_i),
    .production_in_i (production_in_i),
    .coef_x_i        (coef_x_q),
    .coef_y_i        (coef_y_q),
    .time_step_i     (time_step_q),
    .threshold_i     (threshold_q),
    .offset_i        (offset_q),
    .ok_o            (sweep_ok),
    .rd_value_o      (rd_value)
  );

  // Result register. It is loaded once per command; the value field only
  // carries data for a read and the converged flag only for a run.
  logic               out_valid_d;
  logic signed [31:0] out_value_q;
  logic [9:0]         out_iter_q;
  logic               out_conv_q;

  assign out_valid_d = res.load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.load) begin
      out_value_q <= res.is_read ? rd_value : '0;
      out_iter_q  <= res.sweep_count;
      out_conv_q  <= res.is_run && res.converged;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign cell_value_out_o  = out_value_q;
  assign iterations_done_o = out_iter_q;
  assign converged_o       = out_conv_q;

  // A write command presents its result on the following cycle.
  `GDES_ASSERT_IMPL(a_write_result, clk_i, rst_ni, (in_accept && (func_i == gdes_pkg::FUNC_WRITE)) |=> out_valid_o)
  // A read command passes through the read state before its result is registered and presented.
  `GDES_ASSERT_IMPL(a_read_result, clk_i, rst_ni, (in_accept && (func_i == gdes_pkg::FUNC_READ)) |=> ##1 out_valid_o)
  // A converged run has performed at least one sweep.
  `GDES_ASSERT_IMPL(a_conv_iters, clk_i, rst_ni, (out_valid_o && converged_o) |-> (iterations_done_o != 10'd0))
  // The controller never overwrites a result the receiver has not taken.
  `GDES_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, res.load && out_valid_q && out_stall_i)

endmodule

FILE: rtl/gdes_ram.sv
module gdes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/gdes_ctrl.sv
module gdes_ctrl #(
  parameter int GRID_COLS = 64,
  parameter int GRID_ROWS = 64
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       accept_i,
  input  logic [1:0]                                 func_i,
  input  logic [9:0]                                 max_iter_i,
  input  logic                                       ok_i,
  output gdes_pkg::cmd_t                             cmd_o,
  output gdes_pkg::res_t                             res_o,
  output logic [$clog2(GRID_COLS*GRID_ROWS)-1:0]     ctl_addr_o,
  output logic [$clog2(GRID_COLS*GRID_ROWS)-1:0]     center_addr_o,
  output logic                                       idle_o
);

  localparam int N   = GRID_COLS * GRID_ROWS;
  localparam int AW  = $clog2(N);
  localparam int CW  = $clog2(N + GRID_COLS);
  localparam int KCW = $clog2(GRID_COLS);
  localparam int KRW = $clog2(GRID_ROWS);

  gdes_pkg::state_e state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [AW-1:0]  kcnt_q, kcnt_d;
  logic [KCW-1:0] kcol_q, kcol_d;
  logic [KRW-1:0] krow_q, krow_d;
  logic [2:0]     drain_q, drain_d;
  logic [9:0]     iter_q, iter_d;
  logic [9:0]     sweep_count_q, sweep_count_d;
  logic           conv_q, conv_d;
  logic           cv;
  logic [9:0]     iter_inc;

  assign cv       = cnt_q >= CW'(GRID_COLS);
  assign iter_inc = iter_q + 10'd1;

  assign ctl_addr_o    = cnt_q[AW-1:0];
  assign center_addr_o = kcnt_q;
  assign idle_o        = state_q == gdes_pkg::ST_IDLE;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    kcnt_d        = kcnt_q;
    kcol_d        = kcol_q;
    krow_d        = krow_q;
    drain_d       = drain_q;
    iter_d        = iter_q;
    sweep_count_d = sweep_count_q;
    conv_d        = conv_q;
    cmd_o         = '0;
    res_o         = '0;
    res_o.sweep_count = sweep_count_q;
    res_o.converged   = conv_q;

    unique case (state_q)
      gdes_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(N - 1)) begin
          cnt_d   = '0;
          state_d = gdes_pkg::ST_IDLE;
        end
      end
      gdes_pkg::ST_IDLE: begin
        if (accept_i) begin
          unique case (func_i)
            gdes_pkg::FUNC_WRITE: begin
              cmd_o.host_wr = 1'b1;
              res_o.load    = 1'b1;
            end
            gdes_pkg::FUNC_READ: begin
              cmd_o.host_rd = 1'b1;
              state_d       = gdes_pkg::ST_READ;
            end
            gdes_pkg::FUNC_RUN: begin
              iter_d = '0;
              cnt_d  = '0;
              kcnt_d = '0;
              kcol_d = '0;
              krow_d = '0;
              if (max_iter_i == 10'd0) begin
                sweep_count_d = '0;
                conv_d        = 1'b0;
                state_d       = gdes_pkg::ST_CLAMP;
              end else begin
                cmd_o.sweep_init = 1'b1;
                state_d          = gdes_pkg::ST_SWEEP;
              end
            end
            default: begin
              res_o.load = 1'b1;
            end
          endcase
        end
      end
      gdes_pkg::ST_READ: begin
        res_o.load    = 1'b1;
        res_o.is_read = 1'b1;
        state_d       = gdes_pkg::ST_IDLE;
      end
      gdes_pkg::ST_SWEEP: begin
        cmd_o.tag.valid   = cv;
        cmd_o.tag.c_first = kcol_q == '0;
        cmd_o.tag.c_last  = kcol_q == KCW'(GRID_COLS - 1);
        cmd_o.tag.r_first = krow_q == '0;
        cmd_o.tag.r_last  = krow_q == KRW'(GRID_ROWS - 1);
        cnt_d = cnt_q + CW'(1);
        if (cv) begin
          kcnt_d = kcnt_q + AW'(1);
          if (kcol_q == KCW'(GRID_COLS - 1)) begin
            kcol_d = '0;
            krow_d = krow_q + KRW'(1);
          end else begin
            kcol_d = kcol_q + KCW'(1);
          end
        end
        if (cnt_q == CW'(N + GRID_COLS - 1)) begin
          drain_d = '0;
          state_d = gdes_pkg::ST_DRAIN;
        end
      end
      gdes_pkg::ST_DRAIN: begin
        drain_d = drain_q + 3'd1;
        if (drain_q == gdes_pkg::DRAIN_LAST) begin
          iter_d = iter_inc;
          cnt_d  = '0;
          kcnt_d = '0;
          kcol_d = '0;
          krow_d = '0;
          if (ok_i || (iter_inc == max_iter_i)) begin
            sweep_count_d = iter_inc;
            conv_d        = ok_i;
            state_d       = gdes_pkg::ST_CLAMP;
          end else begin
            cmd_o.sweep_init = 1'b1;
            state_d          = gdes_pkg::ST_SWEEP;
          end
        end
      end
      gdes_pkg::ST_CLAMP: begin
        cmd_o.clamp_rd = 1'b1;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(N - 1)) begin
          cnt_d   = '0;
          state_d = gdes_pkg::ST_DONE;
        end
      end
      gdes_pkg::ST_DONE: begin
        res_o.load   = 1'b1;
        res_o.is_run = 1'b1;
        state_d      = gdes_pkg::ST_IDLE;
      end
      default: begin
        state_d = gdes_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= gdes_pkg::ST_CLEAR;
      cnt_q         <= '0;
      kcnt_q        <= '0;
      kcol_q        <= '0;
      krow_q        <= '0;
      drain_q       <= '0;
      iter_q        <= '0;
      sweep_count_q <= '0;
      conv_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      kcnt_q        <= kcnt_d;
      kcol_q        <= kcol_d;
      krow_q        <= krow_d;
      drain_q       <= drain_d;
      iter_q        <= iter_d;
      sweep_count_q <= sweep_count_d;
      conv_q        <= conv_d;
    end
  end

endmodule

FILE: rtl/gdes_datapath.sv
module gdes_datapath #(
  parameter int GRID_COLS  = 64,
  parameter int GRID_ROWS  = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  gdes_pkg::cmd_t                         cmd_i,
  input  logic [$clog2(GRID_COLS*GRID_ROWS)-1:0] ctl_addr_i,
  input  logic [$clog2(GRID_COLS*GRID_ROWS)-1:0] center_addr_i,
  input  logic [5:0]                             col_index_i,
  input  logic [5:0]                             row_index_i,
  input  logic signed [31:0]                     cell_value_in_i,
  input  logic signed [31:0]                     production_in_i,
  input  logic [15:0]                            coef_x_i,
  input  logic [15:0]                            coef_y_i,
  input  logic [15:0]                            time_step_i,
  input  logic [15:0]                            threshold_i,
  input  logic [15:0]                            offset_i,
  output logic                                   ok_o,
  output logic signed [31:0]                     rd_value_o
);

  localparam int N  = GRID_COLS * GRID_ROWS;
  localparam int AW = $clog2(N);
  localparam int VW = VALUE_BITS;
  localparam int WL = 2 * GRID_COLS + 1;

  localparam logic signed [63:0]   VMAX64 = (64'sd1 <<< (VW - 1)) - 64'sd1;
  localparam logic signed [63:0]   VMIN64 = -VMAX64 - 64'sd1;
  localparam logic signed [VW+1:0] VMAX_W = (VW + 2)'(VMAX64);
  localparam logic signed [VW+1:0] VMIN_W = -VMAX_W - (VW + 2)'(1);
  // Signed zero, so that the convergence compares stay signed.
  localparam logic signed [VW-1:0] ZERO_V = '0;

  function automatic logic signed [VW-1:0] sat_w(input logic signed [VW+1:0] x);
    if (x > VMAX_W) begin
      sat_w = VMAX_W[VW-1:0];
    end else if (x < VMIN_W) begin
      sat_w = VMIN_W[VW-1:0];
    end else begin
      sat_w = x[VW-1:0];
    end
  endfunction

  function automatic logic signed [VW-1:0] add_s(input logic signed [VW-1:0] a,
                                                 input logic signed [VW-1:0] b);
    add_s = sat_w((VW + 2)'(a) + (VW + 2)'(b));
  endfunction

  function automatic logic signed [VW-1:0] sub_s(input logic signed [VW-1:0] a,
                                                 input logic signed [VW-1:0] b);
    sub_s = sat_w((VW + 2)'(a) - (VW + 2)'(b));
  endfunction

  // Sign-magnitude product with a Q0.16 factor, truncated toward zero.
  function automatic logic signed [VW-1:0] mul_q(input logic signed [VW-1:0] a,
                                                 input logic [15:0] c);
    logic [VW-1:0]    mag;
    logic [VW+15:0]   prod;
    logic [VW-1:0]    r;
    mag = a;
    if (a[VW-1]) begin
      mag = ~mag + 1'b1;
    end
    prod = (VW + 16)'(mag) * (VW + 16)'(c);
    r    = prod[VW+15:16];
    if (a[VW-1]) begin
      r = ~r + 1'b1;
    end
    mul_q = r;
  endfunction

  function automatic logic signed [VW-1:0] load_val(input logic signed [31:0] x);
    logic signed [63:0] e;
    e = 64'(x);
    if (e > VMAX64) begin
      e = VMAX64;
    end else if (e < VMIN64) begin
      e = VMIN64;
    end
    load_val = e[VW-1:0];
  endfunction

  // Host addressing.
  logic          host_inside;
  logic [AW-1:0] host_addr;
  logic          inside_q;

  assign host_inside = (32'(col_index_i) < 32'(GRID_COLS)) &&
                       (32'(row_index_i) < 32'(GRID_ROWS));
  assign host_addr   = AW'(32'(row_index_i) * 32'(GRID_COLS) + 32'(col_index_i));

  // Memories.
  logic          conc_we, rate_we;
  logic [AW-1:0] conc_waddr, conc_raddr, rate_waddr;
  logic [VW-1:0] conc_wdata, conc_rdata, rate_wdata, rate_rdata;

  gdes_ram #(.WIDTH(VW), .DEPTH(N)) u_conc_ram (
    .clk_i   (clk_i),
    .we_i    (conc_we),
    .waddr_i (conc_waddr),
    .wdata_i (conc_wdata),
    .raddr_i (conc_raddr),
    .rdata_o (conc_rdata)
  );

  gdes_ram #(.WIDTH(VW), .DEPTH(N)) u_rate_ram (
    .clk_i   (clk_i),
    .we_i    (rate_we),
    .waddr_i (rate_waddr),
    .wdata_i (rate_wdata),
    .raddr_i (center_addr_i),
    .rdata_o (rate_rdata)
  );

  // Stencil window and pipeline.
  logic [VW-1:0]          w_q [WL];
  logic signed [VW-1:0]   rate_q;
  gdes_pkg::sweep_tag_t   tag_q [1:2];
  logic                   vld_q [3:6];
  logic [AW-1:0]          kad_q [1:6];
  logic                   clamp_q;
  logic [AW-1:0]          cadr_q;
  logic                   ok_q;

  logic signed [VW-1:0] wv, wl, wr, wu, wd;
  logic signed [VW-1:0] a_v, a_den, a_dl, a_dr, a_du, a_dd, a_rate;
  logic signed [VW-1:0] b_v, b_den, b_tl, b_tr, b_tu, b_td, b_src, b_lim;
  logic signed [VW-1:0] c_v, c_den, c_lim, c_a, c_td, c_src;
  logic signed [VW-1:0] d_v, d_den, d_lim, d_p;
  logic signed [VW-1:0] e_new;
  logic                 e_fail;
  logic [VW-1:0]        clamp_val;

  assign wd = w_q[0];
  assign wr = w_q[GRID_COLS-1];
  assign wv = w_q[GRID_COLS];
  assign wl = w_q[GRID_COLS+1];
  assign wu = w_q[2*GRID_COLS];

  assign e_new  = add_s(d_v, d_p);
  assign e_fail = ((d_den > ZERO_V) && (d_p > d_lim)) ||
                  ((d_den < ZERO_V) && (d_p < d_lim)) ||
                  ((d_den == ZERO_V) && (d_p > ZERO_V));

  assign clamp_val = conc_rdata[VW-1] ? '0 : conc_rdata;

  always_comb begin
    conc_we    = 1'b0;
    conc_waddr = ctl_addr_i;
    conc_wdata = '0;
    if (cmd_i.clear) begin
      conc_we = 1'b1;
    end else if (vld_q[6]) begin
      conc_we    = 1'b1;
      conc_waddr = kad_q[6];
      conc_wdata = e_new;
    end else if (clamp_q) begin
      conc_we    = 1'b1;
      conc_waddr = cadr_q;
      conc_wdata = clamp_val;
    end else if (cmd_i.host_wr && host_inside) begin
      conc_we    = 1'b1;
      conc_waddr = host_addr;
      conc_wdata = load_val(cell_value_in_i);
    end
  end

  assign conc_raddr = cmd_i.host_rd ? host_addr : ctl_addr_i;
  assign rate_we    = cmd_i.clear || (cmd_i.host_wr && host_inside);
  assign rate_waddr = cmd_i.clear ? ctl_addr_i : host_addr;
  assign rate_wdata = cmd_i.clear ? '0 : load_val(production_in_i);

  always_comb begin
    logic signed [63:0] rx;
    rx = 64'(signed'(conc_rdata));
    rd_value_o = inside_q ? rx[31:0] : '0;
  end

  assign ok_o = ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q[1] <= '0;
      tag_q[2] <= '0;
      for (int i = 3; i <= 6; i++) begin
        vld_q[i] <= 1'b0;
      end
      clamp_q <= 1'b0;
      ok_q    <= 1'b1;
    end else begin
      tag_q[1] <= cmd_i.tag;
      tag_q[2] <= tag_q[1];
      vld_q[3] <= tag_q[2].valid;
      for (int i = 4; i <= 6; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
      clamp_q <= cmd_i.clamp_rd;
      if (cmd_i.sweep_init) begin
        ok_q <= 1'b1;
      end else if (vld_q[6] && e_fail) begin
        ok_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    inside_q <= host_inside;
    cadr_q   <= ctl_addr_i;
    rate_q   <= rate_rdata;
    kad_q[1] <= center_addr_i;
    for (int i = 2; i <= 6; i++) begin
      kad_q[i] <= kad_q[i-1];
    end
    w_q[0] <= conc_rdata;
    for (int i = 1; i < WL; i++) begin
      w_q[i] <= w_q[i-1];
    end
    // Differences across each face; an insulated edge contributes nothing.
    a_v    <= wv;
    a_den  <= sat_w((VW + 2)'(wv) + signed'((VW + 2)'(offset_i)));
    a_dl   <= tag_q[2].c_first ? '0 : sub_s(wv, wl);
    a_dr   <= tag_q[2].c_last  ? '0 : sub_s(wr, wv);
    a_du   <= tag_q[2].r_first ? '0 : sub_s(wv, wu);
    a_dd   <= tag_q[2].r_last  ? '0 : sub_s(wd, wv);
    a_rate <= rate_q;
    // Fluxes, source and convergence limit.
    b_v   <= a_v;
    b_den <= a_den;
    b_tl  <= mul_q(a_dl, coef_x_i);
    b_tr  <= mul_q(a_dr, coef_x_i);
    b_tu  <= mul_q(a_du, coef_y_i);
    b_td  <= mul_q(a_dd, coef_y_i);
    b_src <= mul_q(a_rate, time_step_i);
    b_lim <= mul_q(a_den, threshold_i);
    // Accumulate in the order the pairs are visited, each step saturating.
    c_v   <= b_v;
    c_den <= b_den;
    c_lim <= b_lim;
    c_a   <= sub_s(add_s(sub_s('0, b_tl), b_tr), b_tu);
    c_td  <= b_td;
    c_src <= b_src;
    d_v   <= c_v;
    d_den <= c_den;
    d_lim <= c_lim;
    d_p   <= add_s(add_s(c_a, c_td), c_src);
  end

endmodule
